FILE: src/bks_pkg.sv
// Package of sizes, request codes and status codes for the B-tree key store.
`timescale 1ns / 1ps
package bks_pkg;
   localparam int ORDER      = 3;
   localparam int POOL_NODES = 16;
   localparam int KEY_W      = 16;
   localparam int MAXK       = 2 * ORDER - 1;
   localparam int MAXC       = 2 * ORDER;

   localparam int NODE_W   = $clog2(POOL_NODES);
   localparam int CNT_W    = $clog2(POOL_NODES + 1);
   localparam int FILL_W   = $clog2(MAXK + 1);
   localparam int INFO_W   = FILL_W + 1;
   localparam int KADDR_W  = $clog2(POOL_NODES * MAXK);
   localparam int LADDR_W  = $clog2(POOL_NODES * MAXC);

   localparam int REQ_W    = 2;
   localparam int STAT_W   = 2;
   localparam int COUNT_W  = 7;
   localparam int HGT_W    = 5;

   localparam int REQ_TDATA_W = ((KEY_W + 7) / 8) * 8;
   localparam int RSP_BITS    = COUNT_W + HGT_W + 2 * KEY_W + 1;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_BITS;

   localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
   localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd1;
   localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
   localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd2;
   localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd3;
endpackage

FILE: src/bks_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
module bks_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

FILE: src/btree_key_store.sv
// Top level of the B-tree key store: request sequencer over three node memories.
//
// A B-tree of minimum degree ORDER held in a pool of POOL_NODES nodes taken by a bump
// allocator; only a clear returns them. Keys, child links and per-node fill/leaf
// information each live in a RAM with a registered read, and one sequencer walks
// them. One request is taken at a time: a search compares keys level by level, an
// insert compares keys on the way down and shifts larger leaf keys right, and a node
// split copies the upper keys, and for an inner node the upper links, to a new node
// and shifts the parent's keys and links right to take the median. Every request then
// walks the leftmost and rightmost paths of the tree to give the height and the
// minimum and maximum keys. A finished result waits in an output register while the
// next request is already being accepted. No clearing pass is needed after reset or
// clear: every node entry is written before it is read.
`timescale 1ns / 1ps
module btree_key_store (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [bks_pkg::REQ_TDATA_W-1:0]   req_tdata,   // key
   input  logic [bks_pkg::REQ_W-1:0]         req_tuser,   // req_type
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // key_count, tree_height, min_key, max_key, tree_empty, zero padding
   output logic [bks_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic [bks_pkg::STAT_W-1:0]        rsp_tuser    // status
);
   import bks_pkg::*;

   localparam int NS = 39;
   typedef enum logic [NS-1:0] {
      S_IDLE      = NS'(1),
      S_INS_ROOT  = NS'(1) << 1,
      S_SPL_START = NS'(1) << 2,
      S_SPL_KRD   = NS'(1) << 3,
      S_SPL_KWR   = NS'(1) << 4,
      S_SPL_MRD   = NS'(1) << 5,
      S_SPL_MED   = NS'(1) << 6,
      S_SPL_LRD   = NS'(1) << 7,
      S_SPL_LWR   = NS'(1) << 8,
      S_SPL_INFO  = NS'(1) << 9,
      S_SPL_INFOC = NS'(1) << 10,
      S_SPL_PL    = NS'(1) << 11,
      S_SPL_PLW   = NS'(1) << 12,
      S_SPL_PK    = NS'(1) << 13,
      S_SPL_PKW   = NS'(1) << 14,
      S_SPL_PINFO = NS'(1) << 15,
      S_DESC      = NS'(1) << 16,
      S_LF        = NS'(1) << 17,
      S_LFC       = NS'(1) << 18,
      S_LF_DONE   = NS'(1) << 19,
      S_NF        = NS'(1) << 20,
      S_NFC       = NS'(1) << 21,
      S_NL        = NS'(1) << 22,
      S_NLC       = NS'(1) << 23,
      S_NCI       = NS'(1) << 24,
      S_SR_INFO   = NS'(1) << 25,
      S_SR_K      = NS'(1) << 26,
      S_SR_KC     = NS'(1) << 27,
      S_SR_END    = NS'(1) << 28,
      S_SR_LNK    = NS'(1) << 29,
      S_SUM_START = NS'(1) << 30,
      S_MN_INFO   = NS'(1) << 31,
      S_MN_LNK    = NS'(1) << 32,
      S_MN_KEY    = NS'(1) << 33,
      S_MX_START  = NS'(1) << 34,
      S_MX_INFO   = NS'(1) << 35,
      S_MX_LNK    = NS'(1) << 36,
      S_MX_KEY    = NS'(1) << 37,
      S_DELIVER   = NS'(1) << 38
   } state_type;

   function automatic logic [KADDR_W-1:0] kaddr(logic [NODE_W-1:0] n, logic [FILL_W-1:0] j);
      return KADDR_W'(n) * KADDR_W'(MAXK) + KADDR_W'(j);
   endfunction

   function automatic logic [LADDR_W-1:0] laddr(logic [NODE_W-1:0] n, logic [FILL_W-1:0] j);
      return LADDR_W'(n) * LADDR_W'(MAXC) + LADDR_W'(j);
   endfunction

   state_type state_ff, state_in;
   logic              root_valid_ff, root_valid_in;
   logic [NODE_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]  alloc_ptr_ff, alloc_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic signed [KEY_W-1:0] key_ff, key_in;
   logic [STAT_W-1:0]       status_ff, status_in;
   logic [NODE_W-1:0]       node_ff, node_in;
   logic [FILL_W-1:0]       fill_ff, fill_in;
   logic                    leaf_ff, leaf_in;
   logic [FILL_W-1:0]       idx_ff, idx_in;
   logic [NODE_W-1:0]       par_ff, par_in;
   logic [FILL_W-1:0]       pos_ff, pos_in;
   logic [FILL_W-1:0]       pfill_ff, pfill_in;
   logic [NODE_W-1:0]       child_ff, child_in;
   logic                    cleaf_ff, cleaf_in;
   logic [NODE_W-1:0]       newn_ff, newn_in;
   logic [KEY_W-1:0]        med_ff, med_in;
   logic                    from_root_ff, from_root_in;
   logic [HGT_W-1:0]        hgt_ff, hgt_in;
   logic [KEY_W-1:0]        mn_ff, mn_in;
   logic [KEY_W-1:0]        mx_ff, mx_in;

   logic [STAT_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [HGT_W-1:0]   rsp_hgt_ff, rsp_hgt_in;
   logic [KEY_W-1:0]   rsp_mn_ff, rsp_mn_in;
   logic [KEY_W-1:0]   rsp_mx_ff, rsp_mx_in;
   logic               rsp_empty_ff, rsp_empty_in;

   logic               key_we, link_we, info_we;
   logic [KADDR_W-1:0] key_waddr, key_raddr;
   logic [LADDR_W-1:0] link_waddr, link_raddr;
   logic [NODE_W-1:0]  info_waddr, info_raddr;
   logic [KEY_W-1:0]   key_wdata, key_rdata;
   logic [NODE_W-1:0]  link_wdata, link_rdata;
   logic [INFO_W-1:0]  info_wdata, info_rdata;
   logic [FILL_W-1:0]  rd_fill;
   logic               rd_leaf;
   logic               pool_full;

   assign rd_fill   = info_rdata[FILL_W-1:0];
   assign rd_leaf   = info_rdata[FILL_W];
   assign pool_full = alloc_ptr_ff >= CNT_W'(POOL_NODES);

   bks_ram #(.WIDTH(KEY_W), .DEPTH(POOL_NODES * MAXK)) u_key_ram (
      .clock(clock), .wr_en(key_we), .wr_addr(key_waddr), .wr_data(key_wdata),
      .rd_addr(key_raddr), .rd_data(key_rdata)
   );

   bks_ram #(.WIDTH(NODE_W), .DEPTH(POOL_NODES * MAXC)) u_link_ram (
      .clock(clock), .wr_en(link_we), .wr_addr(link_waddr), .wr_data(link_wdata),
      .rd_addr(link_raddr), .rd_data(link_rdata)
   );

   bks_ram #(.WIDTH(INFO_W), .DEPTH(POOL_NODES)) u_info_ram (
      .clock(clock), .wr_en(info_we), .wr_addr(info_waddr), .wr_data(info_wdata),
      .rd_addr(info_raddr), .rd_data(info_rdata)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {RSP_PAD_W'(0), rsp_empty_ff, rsp_mx_ff, rsp_mn_ff, rsp_hgt_ff,
                        rsp_count_ff};

   always_comb begin
      state_in      = state_ff;
      root_valid_in = root_valid_ff;
      root_in       = root_ff;
      alloc_ptr_in  = alloc_ptr_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      key_in        = key_ff;
      status_in     = status_ff;
      node_in       = node_ff;
      fill_in       = fill_ff;
      leaf_in       = leaf_ff;
      idx_in        = idx_ff;
      par_in        = par_ff;
      pos_in        = pos_ff;
      pfill_in      = pfill_ff;
      child_in      = child_ff;
      cleaf_in      = cleaf_ff;
      newn_in       = newn_ff;
      med_in        = med_ff;
      from_root_in  = from_root_ff;
      hgt_in        = hgt_ff;
      mn_in         = mn_ff;
      mx_in         = mx_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_hgt_in    = rsp_hgt_ff;
      rsp_mn_in     = rsp_mn_ff;
      rsp_mx_in     = rsp_mx_ff;
      rsp_empty_in  = rsp_empty_ff;
      key_we     = 1'b0;
      link_we    = 1'b0;
      info_we    = 1'b0;
      key_waddr  = '0;
      key_wdata  = '0;
      key_raddr  = '0;
      link_waddr = '0;
      link_wdata = '0;
      link_raddr = '0;
      info_waddr = '0;
      info_wdata = '0;
      info_raddr = '0;

      case (state_ff)
         S_IDLE: begin
            info_raddr = root_ff;
            if (req_tvalid) begin
               key_in      = $signed(req_tdata[KEY_W-1:0]);
               status_in   = STAT_OK;
               node_in     = root_ff;
               state_in    = S_SUM_START;
               case (req_tuser)
                  REQ_INSERT: begin
                     if (!root_valid_ff) begin
                        if (pool_full) begin
                           status_in = STAT_FULL;
                        end else begin
                           info_we       = 1'b1;
                           info_waddr    = alloc_ptr_ff[NODE_W-1:0];
                           info_wdata    = {1'b1, FILL_W'(1)};
                           key_we        = 1'b1;
                           key_waddr     = kaddr(alloc_ptr_ff[NODE_W-1:0], '0);
                           key_wdata     = req_tdata[KEY_W-1:0];
                           root_in       = alloc_ptr_ff[NODE_W-1:0];
                           root_valid_in = 1'b1;
                           alloc_ptr_in  = alloc_ptr_ff + CNT_W'(1);
                           count_in      = count_ff + COUNT_W'(1);
                        end
                     end else begin
                        state_in = S_INS_ROOT;
                     end
                  end
                  REQ_SEARCH: begin
                     if (!root_valid_ff) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        state_in = S_SR_INFO;
                     end
                  end
                  REQ_CLEAR: begin
                     root_valid_in = 1'b0;
                     alloc_ptr_in  = '0;
                     count_in      = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_INS_ROOT: begin
            if (rd_fill == FILL_W'(MAXK)) begin
               if (pool_full) begin
                  status_in = STAT_FULL;
                  state_in  = S_SUM_START;
               end else begin
                  // The new root is kept even if the split below runs out of nodes.
                  info_we      = 1'b1;
                  info_waddr   = alloc_ptr_ff[NODE_W-1:0];
                  info_wdata   = {1'b0, FILL_W'(0)};
                  link_we      = 1'b1;
                  link_waddr   = laddr(alloc_ptr_ff[NODE_W-1:0], '0);
                  link_wdata   = root_ff;
                  par_in       = alloc_ptr_ff[NODE_W-1:0];
                  pos_in       = '0;
                  pfill_in     = '0;
                  child_in     = root_ff;
                  cleaf_in     = rd_leaf;
                  root_in      = alloc_ptr_ff[NODE_W-1:0];
                  alloc_ptr_in = alloc_ptr_ff + CNT_W'(1);
                  from_root_in = 1'b1;
                  state_in     = S_SPL_START;
               end
            end else begin
               node_in  = root_ff;
               fill_in  = rd_fill;
               leaf_in  = rd_leaf;
               state_in = S_DESC;
            end
         end

         S_SPL_START: begin
            if (pool_full) begin
               status_in = STAT_FULL;
               state_in  = S_SUM_START;
            end else begin
               newn_in      = alloc_ptr_ff[NODE_W-1:0];
               alloc_ptr_in = alloc_ptr_ff + CNT_W'(1);
               idx_in       = '0;
               state_in     = S_SPL_KRD;
            end
         end

         S_SPL_KRD: begin
            key_raddr = kaddr(child_ff, idx_ff + FILL_W'(ORDER));
            state_in  = S_SPL_KWR;
         end

         S_SPL_KWR: begin
            key_we    = 1'b1;
            key_waddr = kaddr(newn_ff, idx_ff);
            key_wdata = key_rdata;
            if (idx_ff == FILL_W'(ORDER - 2)) begin
               state_in = S_SPL_MRD;
            end else begin
               idx_in   = idx_ff + FILL_W'(1);
               state_in = S_SPL_KRD;
            end
         end

         S_SPL_MRD: begin
            key_raddr = kaddr(child_ff, FILL_W'(ORDER - 1));
            state_in  = S_SPL_MED;
         end

         S_SPL_MED: begin
            med_in   = key_rdata;
            idx_in   = '0;
            state_in = cleaf_ff ? S_SPL_INFO : S_SPL_LRD;
         end

         S_SPL_LRD: begin
            link_raddr = laddr(child_ff, idx_ff + FILL_W'(ORDER));
            state_in   = S_SPL_LWR;
         end

         S_SPL_LWR: begin
            link_we    = 1'b1;
            link_waddr = laddr(newn_ff, idx_ff);
            link_wdata = link_rdata;
            if (idx_ff == FILL_W'(ORDER - 1)) begin
               state_in = S_SPL_INFO;
            end else begin
               idx_in   = idx_ff + FILL_W'(1);
               state_in = S_SPL_LRD;
            end
         end

         S_SPL_INFO: begin
            info_we    = 1'b1;
            info_waddr = newn_ff;
            info_wdata = {cleaf_ff, FILL_W'(ORDER - 1)};
            state_in   = S_SPL_INFOC;
         end

         S_SPL_INFOC: begin
            info_we    = 1'b1;
            info_waddr = child_ff;
            info_wdata = {cleaf_ff, FILL_W'(ORDER - 1)};
            idx_in     = pfill_ff;
            state_in   = S_SPL_PL;
         end

         S_SPL_PL: begin
            if (idx_ff > pos_ff) begin
               link_raddr = laddr(par_ff, idx_ff);
               state_in   = S_SPL_PLW;
            end else begin
               link_we    = 1'b1;
               link_waddr = laddr(par_ff, pos_ff + FILL_W'(1));
               link_wdata = newn_ff;
               idx_in     = pfill_ff;
               state_in   = S_SPL_PK;
            end
         end

         S_SPL_PLW: begin
            link_we    = 1'b1;
            link_waddr = laddr(par_ff, idx_ff + FILL_W'(1));
            link_wdata = link_rdata;
            idx_in     = idx_ff - FILL_W'(1);
            state_in   = S_SPL_PL;
         end

         S_SPL_PK: begin
            if (idx_ff > pos_ff) begin
               key_raddr = kaddr(par_ff, idx_ff - FILL_W'(1));
               state_in  = S_SPL_PKW;
            end else begin
               key_we    = 1'b1;
               key_waddr = kaddr(par_ff, pos_ff);
               key_wdata = med_ff;
               state_in  = S_SPL_PINFO;
            end
         end

         S_SPL_PKW: begin
            key_we    = 1'b1;
            key_waddr = kaddr(par_ff, idx_ff);
            key_wdata = key_rdata;
            idx_in    = idx_ff - FILL_W'(1);
            state_in  = S_SPL_PK;
         end

         S_SPL_PINFO: begin
            info_we    = 1'b1;
            info_waddr = par_ff;
            info_wdata = {1'b0, pfill_ff + FILL_W'(1)};
            state_in   = S_DESC;
            if (from_root_ff) begin
               node_in = par_ff;
               fill_in = FILL_W'(1);
               leaf_in = 1'b0;
            end else begin
               // Both halves hold ORDER-1 keys; go right when the key exceeds the median.
               node_in = (key_ff > $signed(med_ff)) ? newn_ff : child_ff;
               fill_in = FILL_W'(ORDER - 1);
               leaf_in = cleaf_ff;
            end
         end

         S_DESC: begin
            idx_in   = fill_ff;
            state_in = leaf_ff ? S_LF : S_NF;
         end

         S_LF: begin
            if (idx_ff != '0) begin
               key_raddr = kaddr(node_ff, idx_ff - FILL_W'(1));
               state_in  = S_LFC;
            end else begin
               key_we    = 1'b1;
               key_waddr = kaddr(node_ff, '0);
               key_wdata = key_ff;
               state_in  = S_LF_DONE;
            end
         end

         S_LFC: begin
            key_we    = 1'b1;
            key_waddr = kaddr(node_ff, idx_ff);
            if ($signed(key_rdata) > key_ff) begin
               key_wdata = key_rdata;
               idx_in    = idx_ff - FILL_W'(1);
               state_in  = S_LF;
            end else begin
               key_wdata = key_ff;
               state_in  = S_LF_DONE;
            end
         end

         S_LF_DONE: begin
            info_we    = 1'b1;
            info_waddr = node_ff;
            info_wdata = {1'b1, fill_ff + FILL_W'(1)};
            count_in   = count_ff + COUNT_W'(1);
            status_in  = STAT_OK;
            state_in   = S_SUM_START;
         end

         S_NF: begin
            if (idx_ff != '0) begin
               key_raddr = kaddr(node_ff, idx_ff - FILL_W'(1));
               state_in  = S_NFC;
            end else begin
               state_in = S_NL;
            end
         end

         S_NFC: begin
            if ($signed(key_rdata) > key_ff) begin
               idx_in   = idx_ff - FILL_W'(1);
               state_in = S_NF;
            end else begin
               state_in = S_NL;
            end
         end

         S_NL: begin
            link_raddr = laddr(node_ff, idx_ff);
            state_in   = S_NLC;
         end

         S_NLC: begin
            child_in   = link_rdata;
            info_raddr = link_rdata;
            state_in   = S_NCI;
         end

         S_NCI: begin
            if (rd_fill == FILL_W'(MAXK)) begin
               par_in       = node_ff;
               pos_in       = idx_ff;
               pfill_in     = fill_ff;
               cleaf_in     = rd_leaf;
               from_root_in = 1'b0;
               state_in     = S_SPL_START;
            end else begin
               node_in  = child_ff;
               fill_in  = rd_fill;
               leaf_in  = rd_leaf;
               state_in = S_DESC;
            end
         end

         S_SR_INFO: begin
            fill_in  = rd_fill;
            leaf_in  = rd_leaf;
            idx_in   = '0;
            state_in = S_SR_K;
         end

         S_SR_K: begin
            if (idx_ff < fill_ff) begin
               key_raddr = kaddr(node_ff, idx_ff);
               state_in  = S_SR_KC;
            end else begin
               state_in = S_SR_END;
            end
         end

         S_SR_KC: begin
            if (key_ff > $signed(key_rdata)) begin
               idx_in   = idx_ff + FILL_W'(1);
               state_in = S_SR_K;
            end else if ($signed(key_rdata) == key_ff) begin
               status_in = STAT_OK;
               state_in  = S_SUM_START;
            end else begin
               state_in = S_SR_END;
            end
         end

         S_SR_END: begin
            if (leaf_ff) begin
               status_in = STAT_NOTFOUND;
               state_in  = S_SUM_START;
            end else begin
               link_raddr = laddr(node_ff, idx_ff);
               state_in   = S_SR_LNK;
            end
         end

         S_SR_LNK: begin
            node_in    = link_rdata;
            info_raddr = link_rdata;
            state_in   = S_SR_INFO;
         end

         S_SUM_START: begin
            hgt_in = '0;
            mn_in  = '0;
            mx_in  = '0;
            if (root_valid_ff) begin
               node_in    = root_ff;
               info_raddr = root_ff;
               state_in   = S_MN_INFO;
            end else begin
               state_in = S_DELIVER;
            end
         end

         S_MN_INFO: begin
            hgt_in = hgt_ff + HGT_W'(1);
            if (rd_leaf) begin
               if (rd_fill != '0) begin
                  key_raddr = kaddr(node_ff, '0);
                  state_in  = S_MN_KEY;
               end else begin
                  state_in = S_MX_START;
               end
            end else begin
               link_raddr = laddr(node_ff, '0);
               state_in   = S_MN_LNK;
            end
         end

         S_MN_LNK: begin
            node_in    = link_rdata;
            info_raddr = link_rdata;
            state_in   = S_MN_INFO;
         end

         S_MN_KEY: begin
            mn_in    = key_rdata;
            state_in = S_MX_START;
         end

         S_MX_START: begin
            node_in    = root_ff;
            info_raddr = root_ff;
            state_in   = S_MX_INFO;
         end

         S_MX_INFO: begin
            if (rd_leaf) begin
               if (rd_fill != '0) begin
                  key_raddr = kaddr(node_ff, rd_fill - FILL_W'(1));
                  state_in  = S_MX_KEY;
               end else begin
                  state_in = S_DELIVER;
               end
            end else begin
               link_raddr = laddr(node_ff, rd_fill);
               state_in   = S_MX_LNK;
            end
         end

         S_MX_LNK: begin
            node_in    = link_rdata;
            info_raddr = link_rdata;
            state_in   = S_MX_INFO;
         end

         S_MX_KEY: begin
            mx_in    = key_rdata;
            state_in = S_DELIVER;
         end

         S_DELIVER: begin
            // Hold until the previous result has left the output register.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_count_in  = count_ff;
               rsp_hgt_in    = hgt_ff;
               rsp_mn_in     = mn_ff;
               rsp_mx_in     = mx_ff;
               rsp_empty_in  = ~root_valid_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         root_valid_ff <= 1'b0;
         root_ff       <= '0;
         alloc_ptr_ff  <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         root_valid_ff <= root_valid_in;
         root_ff       <= root_in;
         alloc_ptr_ff  <= alloc_ptr_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      status_ff     <= status_in;
      node_ff       <= node_in;
      fill_ff       <= fill_in;
      leaf_ff       <= leaf_in;
      idx_ff        <= idx_in;
      par_ff        <= par_in;
      pos_ff        <= pos_in;
      pfill_ff      <= pfill_in;
      child_ff      <= child_in;
      cleaf_ff      <= cleaf_in;
      newn_ff       <= newn_in;
      med_ff        <= med_in;
      from_root_ff  <= from_root_in;
      hgt_ff        <= hgt_in;
      mn_ff         <= mn_in;
      mx_ff         <= mx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_hgt_ff    <= rsp_hgt_in;
      rsp_mn_ff     <= rsp_mn_in;
      rsp_mx_ff     <= rsp_mx_in;
      rsp_empty_ff  <= rsp_empty_in;
   end
endmodule
